// ----- rtl/sbcb_pkg.sv -----
// Shared types, widths and register codes for the sphere box clip block.
// No dependencies.
package sbcb_pkg;
  localparam int COORD_BITS = 32;
  localparam int FRAC_BITS  = 16;
  localparam int RAD_BITS   = COORD_BITS - 1;
  localparam int EXT_BITS   = COORD_BITS + 2;
  localparam int SQ_BITS    = 2 * COORD_BITS;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CENTER_Z = 2'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_RADIUS   = 2'd3;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // One in-flight item: valid and empty flags, box bounds, and per face a remainder under square root and its root.
  typedef struct packed {
    logic                  vld;
    logic                  empty;
    coord_t [2:0]          lo;
    coord_t [2:0]          hi;
    logic   [5:0]          use_r;
    logic   [5:0][SQ_BITS-1:0] rem;
    logic   [5:0][RAD_BITS-1:0] root;
  } sbcb_item_t;
endpackage

// ----- rtl/sphere_box_clip_bounds.sv -----
// Sphere box clip bounds: clips an axis-aligned Q16.16 box to a sphere.
// Depends on sbcb_pkg and sbcb_root_cell.
//
// Accepts one box beat per cycle unless a finished beat is held by output
// stall. Each result passes through the head register, the chain of
// square-root cells (one root bit per cell) and the output register. Output
// stall on a finished beat freezes the whole chain, and input stall is raised
// exactly while it does. The user must write sphere centre and radius through
// cfg_* only while the block is idle; the block does not enforce it. Every
// index selects a register. Empty results have zero bounds and box_empty high.
module sphere_box_clip_bounds import sbcb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_index,
  input  logic [COORD_BITS-1:0] cfg_data,
  input  logic in_valid,
  output logic in_stall,
  input  coord_t in_box_min_x, input coord_t in_box_min_y, input coord_t in_box_min_z,
  input  coord_t in_box_max_x, input coord_t in_box_max_y, input coord_t in_box_max_z,
  output logic out_valid,
  input  logic out_stall,
  output coord_t out_clip_min_x, output coord_t out_clip_min_y, output coord_t out_clip_min_z,
  output coord_t out_clip_max_x, output coord_t out_clip_max_y, output coord_t out_clip_max_z,
  output logic out_box_empty
);
  coord_t cen_r [3];
  logic [RAD_BITS-1:0] rad_r;
  logic adv;
  sbcb_item_t head_r, head_nxt;
  sbcb_item_t chain [RAD_BITS+1];
  sbcb_item_t tail;
  logic signed [EXT_BITS-1:0] lo_e, hi_e, c_e, r_e, dmn, dmx;

  // Advance everything unless a finished beat is held.
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cen_r[0] <= '0; cen_r[1] <= '0; cen_r[2] <= '0; rad_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_X: cen_r[0] <= cfg_data;
        REG_CENTER_Y: cen_r[1] <= cfg_data;
        REG_CENTER_Z: cen_r[2] <= cfg_data;
        REG_RADIUS:   rad_r    <= cfg_data[RAD_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Head stage: face distances, miss test and r^2 - d^2 for each face.
  always_comb begin
    head_nxt = '0;
    head_nxt.vld = in_valid;
    head_nxt.lo = {in_box_min_z, in_box_min_y, in_box_min_x};
    head_nxt.hi = {in_box_max_z, in_box_max_y, in_box_max_x};
    r_e = EXT_BITS'($signed({1'b0, rad_r}));
    for (int c = 0; c < 3; c++) begin
      lo_e = EXT_BITS'(head_nxt.lo[c]);
      hi_e = EXT_BITS'(head_nxt.hi[c]);
      c_e  = EXT_BITS'(cen_r[c]);
      dmn  = lo_e - c_e;
      dmx  = c_e - hi_e;
      if (dmn > r_e || dmx > r_e) head_nxt.empty = 1'b1;
      head_nxt.use_r[2*c]   = !(dmn > 0);
      head_nxt.use_r[2*c+1] = !(dmx > 0);
      head_nxt.rem[2*c]   = SQ_BITS'(unsigned'(r_e - dmn)) * SQ_BITS'(unsigned'(r_e + dmn));
      head_nxt.rem[2*c+1] = SQ_BITS'(unsigned'(r_e - dmx)) * SQ_BITS'(unsigned'(r_e + dmx));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r.vld <= 1'b0;
    end else if (adv) begin
      head_r <= head_nxt;
    end
  end

  assign chain[0] = head_r;
  for (genvar k = 0; k < RAD_BITS; k++) begin : g_cell
    sbcb_root_cell u_cell (
      .clk(clk), .rst_n(rst_n), .adv(adv),
      .bit_sel(6'(RAD_BITS - 1 - k)),
      .item_in(chain[k]), .item_out(chain[k+1])
    );
  end
  assign tail = chain[RAD_BITS];

  // Output register: clamp the two other axes by each face's half-width.
  logic out_vld_r, out_emp_r;
  coord_t olo_r [3], ohi_r [3];
  logic signed [EXT_BITS-1:0] nlo [3], nhi [3], qe, ca;
  logic emp;
  always_comb begin
    emp = tail.empty;
    for (int c = 0; c < 3; c++) begin
      nlo[c] = EXT_BITS'(tail.lo[c]);
      nhi[c] = EXT_BITS'(tail.hi[c]);
    end
    ca = '0; qe = '0;
    for (int f = 0; f < 6; f++) begin
      qe = tail.use_r[f] ? EXT_BITS'($signed({1'b0, rad_r}))
                         : EXT_BITS'($signed({1'b0, tail.root[f]}));
      for (int o = 1; o < 3; o++) begin
        ca = EXT_BITS'(cen_r[(f/2+o)%3]);
        if (ca - qe > nlo[(f/2+o)%3]) nlo[(f/2+o)%3] = ca - qe;
        if (ca + qe < nhi[(f/2+o)%3]) nhi[(f/2+o)%3] = ca + qe;
      end
    end
    for (int c = 0; c < 3; c++) if (nhi[c] <= nlo[c]) emp = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= tail.vld;
      out_emp_r <= emp;
      for (int c = 0; c < 3; c++) begin
        olo_r[c] <= emp ? '0 : nlo[c][COORD_BITS-1:0];
        ohi_r[c] <= emp ? '0 : nhi[c][COORD_BITS-1:0];
      end
    end
  end

  assign out_valid = out_vld_r;
  assign out_box_empty = out_emp_r;
  assign out_clip_min_x = olo_r[0]; assign out_clip_min_y = olo_r[1];
  assign out_clip_min_z = olo_r[2]; assign out_clip_max_x = ohi_r[0];
  assign out_clip_max_y = ohi_r[1]; assign out_clip_max_z = ohi_r[2];
endmodule

// ----- rtl/sbcb_root_cell.sv -----
// One cell of the square root chain: resolves one root bit of all six faces.
// Depends on sbcb_pkg.
module sbcb_root_cell import sbcb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                adv,
  input  logic [5:0]          bit_sel,
  input  sbcb_item_t          item_in,
  output sbcb_item_t          item_out
);
  sbcb_item_t item_r, item_nxt;

  // Root bits are set MSB-first; bit_sel is the index of the cell's root bit.
  always_comb begin
    logic [SQ_BITS-1:0] cand;
    logic [RAD_BITS-1:0] trial;
    item_nxt = item_in;
    for (int f = 0; f < 6; f++) begin
      trial = item_in.root[f] | (RAD_BITS'(1) << bit_sel);
      cand  = SQ_BITS'(trial) * SQ_BITS'(trial);
      if (cand <= item_in.rem[f]) item_nxt.root[f] = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else if (adv) begin
      item_r <= item_nxt;
    end
  end

  assign item_out = item_r;
endmodule

// ----- verif/sphere_box_clip_bounds_tb.sv -----
// Self-checking bench for sphere_box_clip_bounds: random and directed box beats,
// clip results predicted in-bench. Depends on sbcb_pkg and the block's RTL.
`timescale 1ns / 1ps

module sphere_box_clip_bounds_tb;
  import sbcb_pkg::*;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
  } box_t;

  typedef struct packed {
    coord_t [2:0] lo;
    coord_t [2:0] hi;
    logic         empty;
  } clip_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = REG_CENTER_X;
  logic [COORD_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_taken = 1'b0;
  coord_t in_lo [3] = '{default: '0};
  coord_t in_hi [3] = '{default: '0};
  logic out_valid;
  logic out_stall = 1'b0;
  coord_t out_lo [3];
  coord_t out_hi [3];
  logic out_box_empty;

  // Sphere copy held by the predictor.
  longint sph_cen [3];
  longint sph_rad;

  box_t  pending_boxes[$];
  clip_t expected_clips[$];
  int    mismatches = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_off_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sphere_box_clip_bounds DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall,
    .in_box_min_x(in_lo[0]), .in_box_min_y(in_lo[1]), .in_box_min_z(in_lo[2]),
    .in_box_max_x(in_hi[0]), .in_box_max_y(in_hi[1]), .in_box_max_z(in_hi[2]),
    .out_valid, .out_stall,
    .out_clip_min_x(out_lo[0]), .out_clip_min_y(out_lo[1]), .out_clip_min_z(out_lo[2]),
    .out_clip_max_x(out_hi[0]), .out_clip_max_y(out_hi[1]), .out_clip_max_z(out_hi[2]),
    .out_box_empty
  );

  // floor(sqrt(a*b)), bit by bit over 128-bit products.
  function automatic longint chord_root(longint a, longint b);
    logic [127:0] n, c2;
    longint q, c;
    n = 128'(a) * 128'(b);
    q = 0;
    for (int bit_i = COORD_BITS - 1; bit_i >= 0; bit_i--) begin
      c = q | (64'd1 << bit_i);
      c2 = 128'(c) * 128'(c);
      if (c2 <= n) q = c;
    end
    return q;
  endfunction

  function automatic clip_t predict_clip(box_t b);
    longint lo [3], hi [3];
    longint q [2], d [2], a, h;
    int c1, c2;
    clip_t res;
    logic miss;
    miss = 1'b0;
    for (int c = 0; c < 3; c++) begin
      lo[c] = longint'(b.lo[c]);
      hi[c] = longint'(b.hi[c]);
      if (sph_cen[c] - lo[c] < -sph_rad || sph_cen[c] - hi[c] > sph_rad) miss = 1'b1;
    end
    if (!miss) begin
      for (int c = 0; c < 3; c++) begin
        c1 = (c + 1) % 3;
        c2 = (c + 2) % 3;
        d[0] = lo[c] - sph_cen[c];
        d[1] = sph_cen[c] - hi[c];
        for (int f = 0; f < 2; f++) begin
          q[f] = (d[f] > 0) ? chord_root(sph_rad - d[f], sph_rad + d[f]) : sph_rad;
          foreach (lo[k]) if (k == c1 || k == c2) begin
            a = sph_cen[k] - q[f];
            h = sph_cen[k] + q[f];
            if (a > lo[k]) lo[k] = a;
            if (h < hi[k]) hi[k] = h;
          end
        end
      end
      for (int c = 0; c < 3; c++) if (hi[c] <= lo[c]) miss = 1'b1;
    end
    for (int c = 0; c < 3; c++) begin
      res.lo[c] = miss ? '0 : coord_t'(lo[c]);
      res.hi[c] = miss ? '0 : coord_t'(hi[c]);
    end
    res.empty = miss;
    return res;
  endfunction

  // Driver: present the head of the queue, hold it until the block takes it.
  always @(negedge clk) begin
    if (in_taken) begin
      void'(pending_boxes.pop_front());
    end
    if (pending_boxes.size() > 0 && ((in_valid && !in_taken) ||
        $urandom_range(99) >= send_idle_pct)) begin
      in_valid <= 1'b1;
      for (int c = 0; c < 3; c++) begin
        in_lo[c] <= pending_boxes[0].lo[c];
        in_hi[c] <= pending_boxes[0].hi[c];
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver: random stalls, or a long hold-off counted down cycle by cycle.
  always @(negedge clk) begin
    if (hold_off_cycles > 0) begin
      out_stall <= 1'b1;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Predict on every accepted input beat; flag it for the driver.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_clips.push_back(predict_clip(pending_boxes[0]));
    end
  end

  // Monitor: compare each output beat against the oldest expectation.
  always @(posedge clk) begin
    clip_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      for (int c = 0; c < 3; c++) begin
        got.lo[c] = out_lo[c];
        got.hi[c] = out_hi[c];
      end
      got.empty = out_box_empty;
      if (expected_clips.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected output beat %p", got);
      end else begin
        want = expected_clips.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("clip mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, longint value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[COORD_BITS-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RADIUS) sph_rad = value & ((64'd1 << RAD_BITS) - 1);
    else sph_cen[idx] = longint'(coord_t'(value[COORD_BITS-1:0]));
  endtask

  task automatic set_sphere(longint cx, longint cy, longint cz, longint r);
    write_reg(REG_CENTER_X, cx);
    write_reg(REG_CENTER_Y, cy);
    write_reg(REG_CENTER_Z, cz);
    write_reg(REG_RADIUS, r);
  endtask

  // Wait for the pipeline to drain before touching the registers.
  task automatic wait_idle();
    while (pending_boxes.size() > 0 || expected_clips.size() > 0) @(posedge clk);
    repeat (RAD_BITS + 8) @(posedge clk);
  endtask

  task automatic add_box(longint x0, longint y0, longint z0,
                         longint x1, longint y1, longint z1);
    box_t b;
    b.lo[0] = coord_t'(x0); b.lo[1] = coord_t'(y0); b.lo[2] = coord_t'(z0);
    b.hi[0] = coord_t'(x1); b.hi[1] = coord_t'(y1); b.hi[2] = coord_t'(z1);
    pending_boxes.push_back(b);
  endtask

  // Boxes mostly around the sphere, some fully random noise.
  task automatic add_random_boxes(int count, longint span);
    box_t b;
    longint p, w;
    repeat (count) begin
      for (int c = 0; c < 3; c++) begin
        if ($urandom_range(9) == 0) begin
          b.lo[c] = coord_t'($urandom());
          b.hi[c] = coord_t'($urandom());
        end else begin
          p = sph_cen[c] + longint'($urandom_range(2 * span)) - span;
          w = longint'($urandom_range(2 * span));
          if ($urandom_range(19) == 0) w = 0;
          if (p < -(64'sd1 << 31)) p = -(64'sd1 << 31);
          if (p + w > (64'sd1 << 31) - 1) p = (64'sd1 << 31) - 1 - w;
          if (p < -(64'sd1 << 31)) p = -(64'sd1 << 31);
          b.lo[c] = coord_t'(p);
          b.hi[c] = coord_t'(p + w);
        end
      end
      pending_boxes.push_back(b);
    end
  endtask

  function automatic longint rand_coord();
    return longint'(coord_t'($urandom()));
  endfunction

  initial begin
    longint big, neg;
    big = (64'sd1 << 31) - 1;
    neg = -(64'sd1 << 31);
    sph_cen = '{0, 0, 0};
    sph_rad = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Radius zero after reset: every box collapses.
    add_box(-65536, -65536, -65536, 65536, 65536, 65536);
    wait_idle();

    set_sphere(0, 0, 0, 10 << 16);
    add_box(-65536, -65536, -65536, 65536, 65536, 65536);  // fully inside
    add_box(20 << 16, -65536, -65536, 30 << 16, 65536, 65536);  // centre far outside
    add_box(5 << 16, -(20 << 16), -(20 << 16), 20 << 16, 20 << 16, 20 << 16);
    add_box(-(20 << 16), 3 << 16, -(20 << 16), 20 << 16, 20 << 16, -(4 << 16));
    add_box(-65536, 0, -65536, 65536, 0, 65536);  // zero extent
    add_box(65536, 65536, 65536, -65536, -65536, -65536);  // inverted
    add_box(8 << 16, 8 << 16, 8 << 16, 9 << 16, 9 << 16, 9 << 16);  // corner miss
    add_box(10 << 16, -65536, -65536, 11 << 16, 65536, 65536);  // grazing face
    add_box(neg, neg, neg, big, big, big);
    wait_idle();

    // Extremes of centre and radius.
    set_sphere(big, neg, big, big);
    add_box(neg, neg, neg, big, big, big);
    add_box(0, neg, 0, big, 0, big);
    add_box(big, big, big, big, big, big);
    add_box(neg, big, neg, neg, big, neg);
    add_box(-1, -1, -1, 0, 0, 0);
    wait_idle();
    set_sphere(neg, big, neg, 1);
    add_box(neg, big - 1, neg, neg + 1, big, neg + 1);
    add_box(neg, neg, neg, big, big, big);
    wait_idle();

    // Random phases over several spheres and idling mixes.
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if (ph == 7) set_sphere(rand_coord(), rand_coord(), rand_coord(), $urandom() >> 1);
      else set_sphere(rand_coord() >>> 2, rand_coord() >>> 2, rand_coord() >>> 2,
                      $urandom_range(32'h3fff_ffff));
      add_random_boxes(220, (sph_rad * 3) / 2 + 1);
      if (ph == 0) hold_off_cycles = 200;  // long receiver hold: fill the pipe
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("sphere_box_clip_bounds verification clean");
    end else begin
      $display("sphere_box_clip_bounds verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sphere_box_clip_bounds verification failed");
    $finish;
  end

endmodule
